// File: design/tit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tit_pkg: shared types and constants of the triangle incidence table
// item kinds, status codes, payload structs
// ----------------------------------------------------------------------------
package tit_pkg;
  localparam int TRI_DEPTH = 64;
  localparam int NODE_BITS = 16;
  localparam int ID_BITS = $clog2(TRI_DEPTH);
  localparam int SLOT_BITS = 3 * NODE_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_DEL = 3'd1;
  localparam logic [2:0] KIND_FIND = 3'd2;
  localparam logic [2:0] KIND_NODE = 3'd3;
  localparam logic [2:0] KIND_EDGE = 3'd4;
  localparam logic [2:0] KIND_GET = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_EXISTS = 3'd2;
  localparam logic [2:0] ST_UNK_TRI = 3'd3;
  localparam logic [2:0] ST_UNK_NODE = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] node_a;
    logic [15:0] node_b;
    logic [15:0] node_c;
    logic [5:0] tri_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic found;
    logic [5:0] result_tri;
    logic [15:0] node_lo;
    logic [15:0] node_mid;
    logic [15:0] node_hi;
    logic last;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic [2:0] kind;
    logic dup;
    logic [NODE_BITS-1:0] a;
    logic [NODE_BITS-1:0] b;
    logic [NODE_BITS-1:0] c;
    logic [NODE_BITS-1:0] lo;
    logic [NODE_BITS-1:0] mid;
    logic [NODE_BITS-1:0] hi;
    logic [5:0] tri_id;
  } op_t;
endpackage

// File: design/tit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tit_in_if / tit_out_if: valid/ready channels
// one transaction moves one item
// ----------------------------------------------------------------------------
interface tit_in_if;
  logic valid;
  logic ready;
  tit_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tit_out_if;
  logic valid;
  logic ready;
  tit_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: design/tit_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tit_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module tit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/tit_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tit_front: accepts transactions, truncates and sorts the nodes
// and pushes a classified operation into a short queue
// ----------------------------------------------------------------------------
module tit_front (
  input  logic clk,
  input  logic rst,
  tit_in_if.sink in_ch,
  output logic q_valid,
  input  logic q_pop,
  output tit_pkg::op_t q_head
);
  localparam int QP = $clog2(tit_pkg::QUEUE_DEPTH);
  tit_pkg::op_t buffer [tit_pkg::QUEUE_DEPTH];
  logic [QP-1:0] wr_ptr;
  logic [QP-1:0] rd_ptr;
  logic [QP:0] count;
  tit_pkg::op_t op;
  logic [tit_pkg::NODE_BITS-1:0] x0, x1, x2, y0, y1, y2;
  logic push;

  // sorting network and duplicate check
  always_comb begin
    x0 = in_ch.data.node_a[tit_pkg::NODE_BITS-1:0];
    x1 = in_ch.data.node_b[tit_pkg::NODE_BITS-1:0];
    x2 = in_ch.data.node_c[tit_pkg::NODE_BITS-1:0];
    y0 = (x0 > x1) ? x1 : x0;
    y1 = (x0 > x1) ? x0 : x1;
    y2 = x2;
    if (y1 > y2) begin
      y2 = y1;
      y1 = x2;
    end
    if (y0 > y1) begin
      op.lo = y1;
      op.mid = y0;
    end else begin
      op.lo = y0;
      op.mid = y1;
    end
    op.hi = y2;
    op.kind = in_ch.data.kind;
    op.a = x0;
    op.b = x1;
    op.c = x2;
    op.tri_id = in_ch.data.tri_id;
    op.dup = (op.lo == op.mid) || (op.mid == op.hi);
  end

  assign in_ch.ready = (count != (QP + 1)'(tit_pkg::QUEUE_DEPTH));
  // unused kinds produce nothing and are dropped here
  assign push = in_ch.valid && in_ch.ready && (op.kind <= tit_pkg::KIND_GET);
  assign q_valid = (count != '0);
  assign q_head = buffer[rd_ptr];

  // queue storage and pointers
  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= op;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QP + 1)'(push) - (QP + 1)'(q_pop);
    end
  end
endmodule

// File: design/tit_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tit_back: executes one operation by scanning the slot table (direct read for delete, get)
// one slot per cycle unless a listing waits on the output, results leave through an output register
// ----------------------------------------------------------------------------
module tit_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  tit_pkg::op_t q_head,
  tit_out_if.source out_ch
);
  localparam int IB = tit_pkg::ID_BITS;
  localparam int NB = tit_pkg::NODE_BITS;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LIST = 3'd2;
  localparam logic [2:0] S_DIRECT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  tit_pkg::op_t op;
  logic [tit_pkg::TRI_DEPTH-1:0] slot_valid;
  logic [IB:0] idx;
  logic [IB:0] rd_idx;
  logic rd_live;
  logic ram_we;
  logic [IB-1:0] ram_addr;
  logic [tit_pkg::SLOT_BITS-1:0] ram_rdata;
  logic [NB-1:0] s0, s1, s2;
  logic known_a, known_b, known_c;
  logic hit;
  logic [IB-1:0] hit_id;
  logic have_free;
  logic [IB-1:0] free_id;
  logic any_listed;
  logic pend;
  tit_pkg::out_item_t pend_item;
  logic out_valid;
  tit_pkg::out_item_t out_item;
  tit_pkg::out_item_t res;
  logic slot_match;
  logic list_match;
  logic out_free;
  logic take;
  logic step;
  logic list_take;
  logic direct_ok;
  tit_pkg::out_item_t direct_item;
  tit_pkg::out_item_t list_item;
  logic load;
  tit_pkg::out_item_t load_item;

  assign {s2, s1, s0} = ram_rdata;
  assign out_free = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_item;

  tit_ram #(.WIDTH(tit_pkg::SLOT_BITS), .DEPTH(tit_pkg::TRI_DEPTH)) u_slots (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({op.hi, op.mid, op.lo}), .rdata(ram_rdata));

  // the slot read back this cycle, checked against the operation
  always_comb begin
    slot_match = rd_live && slot_valid[rd_idx[IB-1:0]];
    list_match = slot_match && (s0 == op.a || s1 == op.a || s2 == op.a) &&
      (op.kind == tit_pkg::KIND_NODE || s0 == op.b || s1 == op.b || s2 == op.b);
  end

  // capture, list stepping and listing only on the second pass
  assign take = (state == S_IDLE) && q_valid && !q_pop;
  assign step = out_free || !pend;
  assign list_take = step && have_free && list_match;

  // ram address: scan index, direct id, held slot on a stall, or the write
  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx[IB-1:0];
    if (state == S_IDLE) begin
      ram_addr = q_head.tri_id[IB-1:0];
    end else if (state == S_DIRECT) begin
      ram_addr = op.tri_id[IB-1:0];
    end else if (state == S_LIST && !step) begin
      ram_addr = rd_idx[IB-1:0];
    end else if (state == S_EMIT && op.kind == tit_pkg::KIND_ADD && res.status ==
                 tit_pkg::ST_OK) begin
      ram_we = 1'b1;
      ram_addr = free_id;
    end
  end

  // final single result, built from the scan summary
  always_comb begin
    res = '0;
    res.last = 1'b1;
    unique case (op.kind)
      tit_pkg::KIND_ADD: begin
        res.node_lo = 16'(op.lo);
        res.node_mid = 16'(op.mid);
        res.node_hi = 16'(op.hi);
        if (op.dup) begin
          res.status = tit_pkg::ST_DUP;
        end else if (hit) begin
          res.status = tit_pkg::ST_EXISTS;
          res.result_tri = 6'(hit_id);
        end else if (!have_free) begin
          res.status = tit_pkg::ST_FULL;
        end else begin
          res.result_tri = 6'(free_id);
        end
      end
      tit_pkg::KIND_FIND: begin
        if (!(known_a && known_b && known_c)) begin
          res.status = tit_pkg::ST_UNK_NODE;
        end else if (op.dup) begin
          res.status = tit_pkg::ST_DUP;
          res.node_lo = 16'(op.lo);
          res.node_mid = 16'(op.mid);
          res.node_hi = 16'(op.hi);
        end else if (hit) begin
          res.found = 1'b1;
          res.result_tri = 6'(hit_id);
          res.node_lo = 16'(op.lo);
          res.node_mid = 16'(op.mid);
          res.node_hi = 16'(op.hi);
        end
      end
      default: begin
        if (!known_a || (op.kind == tit_pkg::KIND_EDGE && !known_b)) begin
          res.status = tit_pkg::ST_UNK_NODE;
        end
      end
    endcase
  end

  // delete and get result, and one listed triangle
  always_comb begin
    direct_ok = slot_valid[op.tri_id[IB-1:0]] &&
      (7'(op.tri_id) < 7'(tit_pkg::TRI_DEPTH));
    direct_item = '0;
    direct_item.last = 1'b1;
    if (!direct_ok) begin
      direct_item.status = tit_pkg::ST_UNK_TRI;
    end else begin
      direct_item.found = (op.kind == tit_pkg::KIND_GET);
      direct_item.result_tri = op.tri_id;
      direct_item.node_lo = 16'(s0);
      direct_item.node_mid = 16'(s1);
      direct_item.node_hi = 16'(s2);
    end
    list_item = '0;
    list_item.found = 1'b1;
    list_item.result_tri = 6'(rd_idx[IB-1:0]);
    list_item.node_lo = 16'(s0);
    list_item.node_mid = 16'(s1);
    list_item.node_hi = 16'(s2);
  end

  // what enters the output register this cycle
  always_comb begin
    load = 1'b0;
    load_item = res;
    unique case (state)
      S_DIRECT: begin
        load = out_free;
        load_item = direct_item;
      end
      S_LIST: begin
        load = list_take && pend;
        load_item = pend_item;
      end
      S_DONE: begin
        load = out_free;
        load_item = pend_item;
        load_item.last = 1'b1;
      end
      S_EMIT: begin
        load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
      rd_live <= 1'b0;
      q_pop <= 1'b0;
    end else begin
      q_pop <= take;
      if (load) begin
        out_valid <= 1'b1;
        out_item <= load_item;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            op <= q_head;
            idx <= '0;
            rd_live <= 1'b0;
            known_a <= 1'b0;
            known_b <= 1'b0;
            known_c <= 1'b0;
            hit <= 1'b0;
            hit_id <= '0;
            have_free <= 1'b0;
            free_id <= '0;
            any_listed <= 1'b0;
            pend <= 1'b0;
            if (q_head.kind == tit_pkg::KIND_DEL || q_head.kind == tit_pkg::KIND_GET) begin
              state <= S_DIRECT;
            end else if (q_head.kind == tit_pkg::KIND_NODE ||
                         q_head.kind == tit_pkg::KIND_EDGE) begin
              state <= S_LIST;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_DIRECT: begin
          // ram data for tri_id is held while the result waits
          if (out_free) begin
            if (direct_ok && op.kind == tit_pkg::KIND_DEL) begin
              slot_valid[op.tri_id[IB-1:0]] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          // pass over all slots: known nodes, match, first free slot
          if (idx != (IB + 1)'(tit_pkg::TRI_DEPTH)) begin
            idx <= idx + 1'b1;
            if (!slot_valid[idx[IB-1:0]] && !have_free) begin
              have_free <= 1'b1;
              free_id <= idx[IB-1:0];
            end
          end
          rd_idx <= idx;
          rd_live <= (idx != (IB + 1)'(tit_pkg::TRI_DEPTH));
          if (slot_match) begin
            if (s0 == op.a || s1 == op.a || s2 == op.a) known_a <= 1'b1;
            if (s0 == op.b || s1 == op.b || s2 == op.b) known_b <= 1'b1;
            if (s0 == op.c || s1 == op.c || s2 == op.c) known_c <= 1'b1;
            if (!hit && s0 == op.lo && s1 == op.mid && s2 == op.hi) begin
              hit <= 1'b1;
              hit_id <= rd_idx[IB-1:0];
            end
          end
          if (!rd_live && idx == (IB + 1)'(tit_pkg::TRI_DEPTH)) begin
            state <= S_EMIT;
          end
        end
        S_LIST: begin
          // scan twice over: first pass finds known nodes, second lists (one pass if a node is unknown)
          if (step) begin
            if (list_take) begin
              pend <= 1'b1;
              any_listed <= 1'b1;
              pend_item <= list_item;
            end
            if (slot_match && !(known_a && known_b)) begin
              if (s0 == op.a || s1 == op.a || s2 == op.a) known_a <= 1'b1;
              if (s0 == op.b || s1 == op.b || s2 == op.b) known_b <= 1'b1;
            end
            rd_idx <= idx;
            rd_live <= (idx != (IB + 1)'(tit_pkg::TRI_DEPTH));
            if (idx != (IB + 1)'(tit_pkg::TRI_DEPTH)) begin
              idx <= idx + 1'b1;
            end else if (!rd_live) begin
              if (!have_free) begin
                // have_free marks the second pass here
                have_free <= 1'b1;
                idx <= '0;
                if (!(known_a && (op.kind == tit_pkg::KIND_NODE || known_b))) begin
                  state <= S_EMIT;
                end
              end else if (any_listed || pend) begin
                state <= S_DONE;
              end else begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            pend <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (op.kind == tit_pkg::KIND_ADD && res.status == tit_pkg::ST_OK) begin
              slot_valid[free_id] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/triangle_incidence_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_incidence_table_unit: table of up to 64 sorted-node triangles
// add, delete, find, node and edge listings, read by id
// ----------------------------------------------------------------------------
// delete and get give their result from a direct read of the slot ram;
// add and find take one pass over the table, listings two passes plus
// result stalls (one pass on an unknown node), each pass paced by the
// one-slot-per-cycle read of the slot ram
// one operation at a time in the back end, the front queue holds two more
// reset clears all valid bits at once, no clearing pass
module triangle_incidence_table_unit (
  input logic clk,
  input logic rst,
  tit_in_if.sink in_ch,
  tit_out_if.source out_ch
);
  logic q_valid;
  logic q_pop;
  tit_pkg::op_t q_head;

  tit_front u_front (.clk(clk), .rst(rst), .in_ch(in_ch), .q_valid(q_valid),
    .q_pop(q_pop), .q_head(q_head));

  tit_back u_back (.clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop),
    .q_head(q_head), .out_ch(out_ch));

  // a pop only comes from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> $past(q_valid)) else $error("pop from empty queue");

  // a held result stays unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result dropped while stalled");

  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.data.status <= tit_pkg::ST_FULL))
    else $error("bad status");
endmodule

// File: test/triangle_incidence_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_incidence_table_unit_tb: self-checking bench for the triangle table
// a model of the table predicts every result transaction from the accepted
// operations; directed operations, then random ones on a small node pool,
// fill, thin and query it
module triangle_incidence_table_unit_tb;
  import tit_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 2 * TRI_DEPTH + 40;

  logic clk;
  logic rst;
  tit_in_if in_ch();
  tit_out_if out_ch();

  triangle_incidence_table_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // table image kept by the bench
  bit tbl_valid [TRI_DEPTH];
  logic [NODE_BITS-1:0] tbl_nodes [TRI_DEPTH][3];

  in_item_t pending_ops[$];
  out_item_t expected_results[$];
  logic [15:0] node_pool [16];

  int src_idle_pct;
  int snk_idle_pct;
  int accepted_count;
  int accepted_seen;
  int stall_requests;
  int stall_seen;
  int stall_left;
  int mismatches;
  int cycles;
  bit offering;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic void post_result(logic [2:0] st, logic fnd, logic [5:0] id,
                                      logic [15:0] lo, logic [15:0] mid,
                                      logic [15:0] hi, logic lst);
    out_item_t r;
    r.status = st;
    r.found = fnd;
    r.result_tri = id;
    r.node_lo = lo;
    r.node_mid = mid;
    r.node_hi = hi;
    r.last = lst;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic bit slot_uses(int s, logic [15:0] n);
    return tbl_nodes[s][0] == n || tbl_nodes[s][1] == n || tbl_nodes[s][2] == n;
  endfunction

  function automatic bit node_in_use(logic [15:0] n);
    for (int s = 0; s < TRI_DEPTH; s++)
      if (tbl_valid[s] && slot_uses(s, n)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int slot_of(logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
    for (int s = 0; s < TRI_DEPTH; s++)
      if (tbl_valid[s] && tbl_nodes[s][0] == lo && tbl_nodes[s][1] == mid &&
          tbl_nodes[s][2] == hi) return s;
    return -1;
  endfunction

  // update the table image and queue the results of one operation
  function automatic void apply_table_op(in_item_t op);
    logic [15:0] v [3];
    logic [15:0] t;
    int hit;
    int free_slot;
    int listed;
    int last_idx;
    v[0] = op.node_a;
    v[1] = op.node_b;
    v[2] = op.node_c;
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    case (op.kind)
      KIND_ADD: begin
        if (v[0] == v[1] || v[1] == v[2]) begin
          post_result(ST_DUP, 0, 0, v[0], v[1], v[2], 1);
        end else begin
          hit = slot_of(v[0], v[1], v[2]);
          free_slot = -1;
          for (int s = TRI_DEPTH - 1; s >= 0; s--)
            if (!tbl_valid[s]) free_slot = s;
          if (hit >= 0) begin
            post_result(ST_EXISTS, 0, 6'(hit), v[0], v[1], v[2], 1);
          end else if (free_slot < 0) begin
            post_result(ST_FULL, 0, 0, v[0], v[1], v[2], 1);
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_nodes[free_slot] = v;
            post_result(ST_OK, 0, 6'(free_slot), v[0], v[1], v[2], 1);
          end
        end
      end
      KIND_DEL, KIND_GET: begin
        if (op.tri_id >= TRI_DEPTH || !tbl_valid[op.tri_id]) begin
          post_result(ST_UNK_TRI, 0, 0, 0, 0, 0, 1);
        end else begin
          post_result(ST_OK, op.kind == KIND_GET, op.tri_id, tbl_nodes[op.tri_id][0],
                      tbl_nodes[op.tri_id][1], tbl_nodes[op.tri_id][2], 1);
          if (op.kind == KIND_DEL) tbl_valid[op.tri_id] = 1'b0;
        end
      end
      KIND_FIND: begin
        if (!node_in_use(op.node_a) || !node_in_use(op.node_b) ||
            !node_in_use(op.node_c)) begin
          post_result(ST_UNK_NODE, 0, 0, 0, 0, 0, 1);
        end else if (v[0] == v[1] || v[1] == v[2]) begin
          post_result(ST_DUP, 0, 0, v[0], v[1], v[2], 1);
        end else begin
          hit = slot_of(v[0], v[1], v[2]);
          if (hit < 0) post_result(ST_OK, 0, 0, 0, 0, 0, 1);
          else post_result(ST_OK, 1, 6'(hit), v[0], v[1], v[2], 1);
        end
      end
      KIND_NODE, KIND_EDGE: begin
        if (!node_in_use(op.node_a) ||
            (op.kind == KIND_EDGE && !node_in_use(op.node_b))) begin
          post_result(ST_UNK_NODE, 0, 0, 0, 0, 0, 1);
        end else begin
          listed = 0;
          for (int s = 0; s < TRI_DEPTH; s++)
            if (tbl_valid[s] && slot_uses(s, op.node_a) &&
                (op.kind == KIND_NODE || slot_uses(s, op.node_b))) begin
              post_result(ST_OK, 1, 6'(s), tbl_nodes[s][0], tbl_nodes[s][1],
                          tbl_nodes[s][2], 0);
              listed++;
            end
          if (listed == 0) begin
            post_result(ST_OK, 0, 0, 0, 0, 0, 1);
          end else begin
            last_idx = expected_results.size() - 1;
            expected_results[last_idx].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // input side: prediction at each accepted transaction
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      apply_table_op(in_ch.data);
      accepted_count++;
    end
  end

  // driver: valid stays high until the transaction is taken
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (offering && accepted_count != accepted_seen) begin
        accepted_seen = accepted_count;
        void'(pending_ops.pop_front());
        offering = 1'b0;
      end
      if (!offering) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.data <= pending_ops[0];
          in_ch.valid <= 1'b1;
          offering = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random holds plus long stalls on request
  always @(negedge clk) begin
    if (stall_requests != stall_seen) begin
      stall_seen = stall_requests;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        if (out_ch.data.status !== want.status || out_ch.data.found !== want.found ||
            out_ch.data.result_tri !== want.result_tri ||
            out_ch.data.node_lo !== want.node_lo ||
            out_ch.data.node_mid !== want.node_mid ||
            out_ch.data.node_hi !== want.node_hi || out_ch.data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_ch.data);
        end
      end
    end
  end

  function automatic in_item_t make_op(logic [2:0] k, logic [15:0] a, logic [15:0] b,
                                       logic [15:0] c, logic [5:0] id);
    in_item_t it;
    it.kind = k;
    it.node_a = a;
    it.node_b = b;
    it.node_c = c;
    it.tri_id = id;
    return it;
  endfunction

  // append one operation to the driver queue
  function automatic void queue_op(in_item_t it);
    pending_ops.insert(pending_ops.size(), it);
  endfunction

  function automatic logic [15:0] pick_node();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return node_pool[4'($urandom_range(15))];
  endfunction

  // random operation; add_pct and del_pct shape how full the table runs
  function automatic in_item_t random_op(int add_pct, int del_pct);
    int roll;
    logic [2:0] k;
    roll = $urandom_range(99);
    if (roll < add_pct) k = KIND_ADD;
    else if (roll < add_pct + del_pct) k = KIND_DEL;
    else if (roll < 97) k = 3'($urandom_range(KIND_GET, KIND_FIND));
    else k = 3'($urandom_range(7, 6));
    return make_op(k, pick_node(), pick_node(), pick_node(), 6'($urandom));
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    src_idle_pct = 31;
    snk_idle_pct = 75;
    accepted_count = 0;
    accepted_seen = 0;
    stall_requests = 0;
    stall_seen = 0;
    stall_left = 0;
    mismatches = 0;
    cycles = 0;
    offering = 1'b0;
    for (int s = 0; s < TRI_DEPTH; s++) tbl_valid[s] = 1'b0;
    node_pool[0] = 16'h0000;
    node_pool[1] = 16'hFFFF;
    for (int i = 2; i < 16; i++) node_pool[i] = 16'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every kind, every status but table full, and corners of the fields
    queue_op(make_op(KIND_FIND, 0, 1, 2, 0));
    queue_op(make_op(KIND_ADD, 2, 0, 1, 0));
    queue_op(make_op(KIND_ADD, 16'hFFFF, 1, 2, 0));
    queue_op(make_op(KIND_ADD, 5, 7, 5, 0));
    queue_op(make_op(KIND_ADD, 1, 2, 0, 0));
    queue_op(make_op(KIND_FIND, 0, 0, 1, 0));
    queue_op(make_op(KIND_FIND, 16'hFFFF, 2, 1, 0));
    queue_op(make_op(KIND_FIND, 0, 2, 16'hFFFF, 0));
    queue_op(make_op(KIND_FIND, 0, 9, 1, 0));
    queue_op(make_op(KIND_NODE, 1, 0, 0, 0));
    queue_op(make_op(KIND_NODE, 16'h1234, 0, 0, 0));
    queue_op(make_op(KIND_EDGE, 2, 1, 0, 0));
    queue_op(make_op(KIND_EDGE, 0, 16'hFFFF, 0, 0));
    queue_op(make_op(KIND_EDGE, 2, 2, 0, 0));
    queue_op(make_op(KIND_EDGE, 0, 16'h4321, 0, 0));
    queue_op(make_op(KIND_GET, 0, 0, 0, 6'd1));
    queue_op(make_op(KIND_GET, 0, 0, 0, 6'd63));
    queue_op(make_op(KIND_DEL, 0, 0, 0, 6'd1));
    queue_op(make_op(KIND_DEL, 0, 0, 0, 6'd1));
    queue_op(make_op(KIND_GET, 0, 0, 0, 6'd1));
    queue_op(make_op(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63));
    queue_op(make_op(3'd7, 0, 0, 0, 0));
    queue_op(make_op(KIND_ADD, 16'hFFFF, 0, 16'h8000, 0));
    drain();

    // fill the table up to full, with a long receiver stall while adding
    for (int i = 0; i < 110; i++) begin
      queue_op(random_op(i < 90 ? 85 : 20, 3));
      if (i == 20) stall_requests++;
      while (pending_ops.size() > 8) @(posedge clk);
    end
    drain();

    // mixed traffic with deletes, idling swapped
    src_idle_pct = 75;
    snk_idle_pct = 31;
    for (int i = 0; i < 105; i++) queue_op(random_op(30, 30));
    drain();

    // no idling, queries over a table kept busy
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int i = 0; i < 105; i++) queue_op(random_op(40, 20));
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
